/* rtl/qcr_pkg.sv */
// Shared types, constants and helper functions of the quadrature counter with speed output.
`default_nettype none

package qcr_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_REVERSE_COUNT     = 8'd0;
  localparam logic [7:0] CFG_COUNTS_PER_REV    = 8'd1;
  localparam logic [7:0] CFG_RATIO_NUMERATOR   = 8'd2;
  localparam logic [7:0] CFG_RATIO_DENOMINATOR = 8'd3;

  // Encoder phase codes, A in the upper bit and B in the lower bit.
  localparam logic [1:0] PHASE_00 = 2'b00;
  localparam logic [1:0] PHASE_10 = 2'b10;
  localparam logic [1:0] PHASE_11 = 2'b11;
  localparam logic [1:0] PHASE_01 = 2'b01;

  // Scale factors of the speed math.
  localparam logic [15:0] MS_PER_S   = 16'd1000;
  localparam logic [15:0] MS_PER_MIN = 16'd60000;

  // Step counter width and last step indexes of the shift-add multiplier and the restoring divider.
  localparam int unsigned STEP_W    = 6;
  localparam logic [5:0]  MUL_LAST  = 6'd15;
  localparam logic [5:0]  DIV_LAST  = 6'd63;

  // One input item.
  typedef struct packed {
    logic        mode;
    logic        chan_a;
    logic        chan_b;
    logic [31:0] now_ms;
  } qcr_item_t;

  // One result item.
  typedef struct packed {
    logic               updated;
    logic signed [31:0] counts_per_sec;
    logic signed [31:0] shaft_rpm;
  } qcr_result_t;

  // Configuration registers as seen by the speed engine.
  typedef struct packed {
    logic        reverse_count;
    logic [15:0] counts_per_rev;
    logic [15:0] ratio_numerator;
    logic [15:0] ratio_denominator;
  } qcr_cfg_t;

  // Speed job handed from the decoder to the speed engine.
  typedef struct packed {
    logic        updated;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] dt;
  } qcr_job_t;

  // Speed engine sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_F,
    ST_MUL_R1,
    ST_MUL_R2,
    ST_MUL_D1,
    ST_MUL_D2,
    ST_DIV_F,
    ST_DIV_R,
    ST_OUT
  } qcr_state_t;

  // Next phase in the forward direction: 00 -> 10 -> 11 -> 01 -> 00.
  function automatic logic [1:0] fwd_next(input logic [1:0] phase);
    logic [1:0] nxt;
    unique case (phase)
      PHASE_00: nxt = PHASE_10;
      PHASE_10: nxt = PHASE_11;
      PHASE_11: nxt = PHASE_01;
      PHASE_01: nxt = PHASE_00;
      default:  nxt = PHASE_00;
    endcase
    return nxt;
  endfunction

endpackage

`default_nettype wire

/* rtl/qcr_front.sv */
// Front part: accepts items, decodes quadrature samples and snapshots the count for speed jobs.
`default_nettype none

module qcr_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire qcr_pkg::qcr_item_t   item,
  input  wire logic                 q_full,
  output logic                      q_push,
  output qcr_pkg::qcr_job_t         q_data
);

  logic [1:0]  phase;
  logic [31:0] position_count;
  logic [31:0] last_update_ms;

  logic        accept;
  logic [1:0]  nxt;
  logic        step_fwd;
  logic        step_bwd;
  logic        later;

  // Only compute items need queue space; samples are always taken.
  assign item_stall = item.mode & q_full;
  assign accept     = item_valid & ~item_stall;
  assign q_push     = accept & item.mode;

  // Direction of a phase step.
  always_comb begin
    nxt      = {item.chan_a, item.chan_b};
    step_fwd = (qcr_pkg::fwd_next(phase) == nxt);
    step_bwd = (qcr_pkg::fwd_next(nxt) == phase);
    later    = (item.now_ms > last_update_ms);
  end

  // Speed job built from the count at the moment of the transfer.
  always_comb begin
    q_data.updated = later;
    q_data.neg     = position_count[31];
    q_data.mag     = position_count[31] ? (32'd0 - position_count) : position_count;
    q_data.dt      = item.now_ms - last_update_ms;
  end

  // Phase tracking, position count and update time.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= qcr_pkg::PHASE_00;
      position_count <= '0;
      last_update_ms <= '0;
    end else if (accept) begin
      if (!item.mode) begin
        if (nxt != phase) begin
          phase <= nxt;
          if (step_fwd) begin
            position_count <= position_count + 32'd1;
          end else if (step_bwd) begin
            position_count <= position_count - 32'd1;
          end
        end
      end else if (later) begin
        position_count <= '0;
        last_update_ms <= item.now_ms;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qcr_queue.sv */
// Short first-in first-out queue of speed jobs between the decoder and the speed engine.
`default_nettype none

module qcr_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire qcr_pkg::qcr_job_t  wr_data,
  input  wire logic               pop,
  output qcr_pkg::qcr_job_t       rd_data,
  output logic                    full,
  output logic                    empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  qcr_pkg::qcr_job_t entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full    = (fill == CNT_W'(DEPTH));
  assign empty   = (fill == '0);
  assign rd_data = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/qcr_back.sv */
// Back part: speed engine with a shift-add multiplier, a restoring divider and the result register.
`default_nettype none

module qcr_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire qcr_pkg::qcr_cfg_t    cfg,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire qcr_pkg::qcr_job_t    q_data,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output qcr_pkg::qcr_result_t      result
);

  qcr_pkg::qcr_state_t state;
  qcr_pkg::qcr_state_t state_next;

  logic                      neg;
  logic [31:0]               mag;
  logic [31:0]               dt;
  logic                      upd;
  logic [qcr_pkg::STEP_W-1:0] cnt;

  logic [63:0] mul_a;
  logic [15:0] mul_b;
  logic [63:0] mul_acc;
  logic [63:0] mul_sum;

  logic [63:0] fnum;
  logic [63:0] rnum;
  logic [63:0] fq;
  logic [63:0] div_q;
  logic [63:0] div_r;
  logic [63:0] div_d;
  logic [64:0] div_shift;
  logic [64:0] div_diff;
  logic        div_ge;
  logic [63:0] div_q_next;
  logic [63:0] div_r_next;

  logic [31:0] last_freq;
  logic [31:0] last_rpm;

  logic        mul_last;
  logic        div_last;
  logic        res_load;
  logic [15:0] cpr_eff;
  logic [15:0] den_eff;

  // Saturate a signed magnitude to 32 bits.
  function automatic logic [31:0] sat32(input logic sign, input logic [63:0] q);
    logic [31:0] r;
    if (sign) begin
      r = (q >= 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end else begin
      r = (q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  // A zero divisor register acts as one.
  assign cpr_eff = (cfg.counts_per_rev == '0) ? 16'd1 : cfg.counts_per_rev;
  assign den_eff = (cfg.ratio_denominator == '0) ? 16'd1 : cfg.ratio_denominator;

  // One multiplier bit per cycle.
  assign mul_sum = mul_acc + (mul_b[0] ? mul_a : 64'd0);

  // One quotient bit per cycle.
  always_comb begin
    div_shift  = {div_r, div_q[63]};
    div_diff   = div_shift - {1'b0, div_d};
    div_ge     = (div_shift >= {1'b0, div_d});
    div_r_next = div_ge ? div_diff[63:0] : div_shift[63:0];
    div_q_next = {div_q[62:0], div_ge};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      qcr_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_next = q_data.updated ? qcr_pkg::ST_MUL_F : qcr_pkg::ST_OUT;
        end
      end
      qcr_pkg::ST_MUL_F:  if (mul_last) state_next = qcr_pkg::ST_MUL_R1;
      qcr_pkg::ST_MUL_R1: if (mul_last) state_next = qcr_pkg::ST_MUL_R2;
      qcr_pkg::ST_MUL_R2: if (mul_last) state_next = qcr_pkg::ST_MUL_D1;
      qcr_pkg::ST_MUL_D1: if (mul_last) state_next = qcr_pkg::ST_MUL_D2;
      qcr_pkg::ST_MUL_D2: if (mul_last) state_next = qcr_pkg::ST_DIV_F;
      qcr_pkg::ST_DIV_F:  if (div_last) state_next = qcr_pkg::ST_DIV_R;
      qcr_pkg::ST_DIV_R:  if (div_last) state_next = qcr_pkg::ST_OUT;
      qcr_pkg::ST_OUT:    if (res_load) state_next = qcr_pkg::ST_IDLE;
      default:            state_next = qcr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = (state == qcr_pkg::ST_IDLE) && !q_empty;
    res_load = (state == qcr_pkg::ST_OUT) && (!result_valid || !result_stall);
    mul_last = (cnt == qcr_pkg::MUL_LAST);
    div_last = (cnt == qcr_pkg::DIV_LAST);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qcr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Step counter: restarts with every multiply and divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == qcr_pkg::ST_IDLE) begin
      cnt <= '0;
    end else if ((state == qcr_pkg::ST_DIV_F) || (state == qcr_pkg::ST_DIV_R)) begin
      cnt <= div_last ? '0 : cnt + qcr_pkg::STEP_W'(1);
    end else begin
      cnt <= mul_last ? '0 : cnt + qcr_pkg::STEP_W'(1);
    end
  end

  // Arithmetic datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      qcr_pkg::ST_IDLE: begin
        neg     <= q_data.neg ^ cfg.reverse_count;
        mag     <= q_data.mag;
        dt      <= q_data.dt;
        upd     <= q_data.updated;
        mul_a   <= {32'd0, q_data.mag};
        mul_b   <= qcr_pkg::MS_PER_S;
        mul_acc <= '0;
      end
      qcr_pkg::ST_MUL_F, qcr_pkg::ST_MUL_R1, qcr_pkg::ST_MUL_R2,
      qcr_pkg::ST_MUL_D1, qcr_pkg::ST_MUL_D2: begin
        if (!mul_last) begin
          mul_acc <= mul_sum;
          mul_a   <= {mul_a[62:0], 1'b0};
          mul_b   <= {1'b0, mul_b[15:1]};
        end else begin
          mul_acc <= '0;
          unique case (state)
            qcr_pkg::ST_MUL_F: begin
              fnum  <= mul_sum;
              mul_a <= {32'd0, mag};
              mul_b <= qcr_pkg::MS_PER_MIN;
            end
            qcr_pkg::ST_MUL_R1: begin
              mul_a <= mul_sum;
              mul_b <= cfg.ratio_numerator;
            end
            qcr_pkg::ST_MUL_R2: begin
              rnum  <= mul_sum;
              mul_a <= {32'd0, dt};
              mul_b <= cpr_eff;
            end
            qcr_pkg::ST_MUL_D1: begin
              mul_a <= mul_sum;
              mul_b <= den_eff;
            end
            default: begin
              // The last product is the rpm divisor.
              div_q <= fnum;
              div_r <= '0;
              div_d <= {32'd0, dt};
              mul_a <= mul_sum;
            end
          endcase
        end
      end
      qcr_pkg::ST_DIV_F: begin
        if (!div_last) begin
          div_q <= div_q_next;
          div_r <= div_r_next;
        end else begin
          fq    <= div_q_next;
          div_q <= rnum;
          div_r <= '0;
          div_d <= mul_a;
        end
      end
      qcr_pkg::ST_DIV_R: begin
        div_q <= div_q_next;
        div_r <= div_r_next;
      end
      qcr_pkg::ST_OUT: begin
        mul_acc <= '0;
      end
      default: begin
        mul_acc <= '0;
      end
    endcase
  end

  // Last reported speeds, repeated when the time did not advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_freq <= '0;
      last_rpm  <= '0;
    end else if ((state == qcr_pkg::ST_DIV_R) && div_last) begin
      last_freq <= sat32(neg, fq);
      last_rpm  <= sat32(neg, div_q_next);
    end
  end

  // Result register: a finished result waits here while the engine goes on.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.updated        <= upd;
      result.counts_per_sec <= $signed(last_freq);
      result.shaft_rpm      <= $signed(last_rpm);
    end
  end

  // A job is taken from the queue only when one is there.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("speed job taken from an empty queue");

  // The rpm division never runs against a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == qcr_pkg::ST_DIV_R) |-> (div_d != 64'd0))
    else $error("rpm division by zero");

  // A result is loaded only after the engine has finished a job.
  a_load_after_job: assert property (@(posedge clk) disable iff (rst)
    res_load |-> ($past(state) == qcr_pkg::ST_OUT || $past(state) == qcr_pkg::ST_DIV_R ||
                  $past(state) == qcr_pkg::ST_IDLE))
    else $error("result loaded outside a finished job");

endmodule

`default_nettype wire

/* rtl/quadrature_counter_with_rpm.sv */
// Top level of the quadrature counter with speed output: configuration registers and wiring.
`default_nettype none

// Sample items (mode 0) are taken one per clock and update the x4 position
// count in the same cycle; a compute item (mode 1) leaves a speed job in a
// queue of QUEUE_DEPTH entries. The speed engine works one job at a time: a
// job whose time advanced goes through fetching the job, five shift-add
// multiplies, two bit-serial divides and loading the result register, and
// a job whose time did not advance goes from fetching the job straight to
// loading the result register. While the engine works, sample items keep
// flowing; only a compute item meeting a full queue is stalled.
// Configuration is written through the cfg port, which is always ready.
module quadrature_counter_with_rpm #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  item_valid,
  output logic                       item_stall,
  input  wire qcr_pkg::qcr_item_t    item,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output qcr_pkg::qcr_result_t       result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [7:0]            cfg_index,
  input  wire logic [15:0]           cfg_data
);

  qcr_pkg::qcr_cfg_t cfg;
  qcr_pkg::qcr_job_t push_data;
  qcr_pkg::qcr_job_t pop_data;
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reverse_count     <= 1'b0;
      cfg.counts_per_rev    <= 16'd1;
      cfg.ratio_numerator   <= 16'd1;
      cfg.ratio_denominator <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        qcr_pkg::CFG_REVERSE_COUNT:     cfg.reverse_count     <= cfg_data[0];
        qcr_pkg::CFG_COUNTS_PER_REV:    cfg.counts_per_rev    <= cfg_data;
        qcr_pkg::CFG_RATIO_NUMERATOR:   cfg.ratio_numerator   <= cfg_data;
        qcr_pkg::CFG_RATIO_DENOMINATOR: cfg.ratio_denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  qcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  qcr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (pop_data),
    .full    (q_full),
    .empty   (q_empty)
  );

  qcr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (pop_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
